// ----- rtl/dltq_pkg.sv -----
// ============================================================================
// dltq_pkg: shared definitions of the delta-list timer queue
// Command and status codes, operation codes of the shared arithmetic unit,
// and the default sizes handed to the top level.
// ============================================================================
package dltq_pkg;

  // Default number of queue entries and width of a relative delay.
  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned DELAY_BITS  = 32;

  // Fixed field widths of the command and result ports.
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned ID_W        = 16;
  localparam int unsigned IN_DELAY_W  = 32;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_OUT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_DUP       = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_e;

  // Operations of the shared add/subtract/compare unit.
  typedef enum logic {
    ALU_SUB     = 1'b0,
    ALU_ADD_SAT = 1'b1
  } alu_op_e;

endpackage

// ----- rtl/delta_list_timer_queue_core.sv -----
// ============================================================================
// delta_list_timer_queue_core: bounded delta-list timer queue
// Keeps up to QUEUE_DEPTH timers in a table sorted by expiry, each entry
// holding an id and its delay relative to the entry before it.
// ============================================================================
// Sequencing: query and tick need no walk. An insert walks the queued entries,
// makes one decision, shifts entries up to open a slot, makes one final write
// and then raises the done strobe; a cancel walks to the match and shifts the
// later entries down. One command is in flight at a time: the entry memory
// has one read and one write port, and the walk and the shift each move one
// entry per cycle through the shared adder.
// Reset: asynchronous, active low; the queue comes up empty and ready, and
// the entry memory needs no clearing. The receiver cannot stall results.
// ============================================================================
module delta_list_timer_queue_core #(
  parameter int unsigned QUEUE_DEPTH = dltq_pkg::QUEUE_DEPTH,
  parameter int unsigned DELAY_BITS  = dltq_pkg::DELAY_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Command transaction: accepted when start is high and busy is low.
  input  logic                             start,
  output logic                             busy,
  input  logic [dltq_pkg::CMD_W-1:0]       command_i,
  input  logic [dltq_pkg::ID_W-1:0]        timer_id_i,
  input  logic [dltq_pkg::IN_DELAY_W-1:0]  delay_i,
  // Result transaction: valid for exactly the one cycle done_o is high.
  output logic                             done_o,
  output logic [dltq_pkg::STATUS_W-1:0]    status_o,
  output logic                             head_expired_o,
  output logic [dltq_pkg::ID_W-1:0]        head_id_o,
  output logic [dltq_pkg::COUNT_OUT_W-1:0] entry_count_o
);

  // Index width addresses one entry; the count must also hold QUEUE_DEPTH.
  localparam int unsigned IW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ID_W  = dltq_pkg::ID_W;
  localparam int unsigned ENT_W = ID_W + DELAY_BITS;

  // The sequencer states. The walk (scan) visits entries head first; the
  // upward shift opens a slot for an insert and the downward shift closes
  // the hole left by a cancel.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHUP,
    ST_WRNEW,
    ST_SHDN,
    ST_TICK
  } state_e;

  state_e                    state_q, state_d;
  logic [IW-1:0]             idx_q, idx_d;
  logic [CW-1:0]             count_q, count_d;
  logic                      done_q, done_d;
  dltq_pkg::status_e         status_q, status_d;
  logic                      placed_q, placed_d;
  logic                      dup_q, dup_d;

  // Payload of the command in flight.
  dltq_pkg::cmd_e            cmd_q, cmd_d;
  logic [ID_W-1:0]           id_q, id_d;
  logic [DELAY_BITS-1:0]     rem_q, rem_d;
  logic [IW-1:0]             pos_q, pos_d;

  // Shadow copy of entry 0, so results and ticks never wait on the memory.
  logic [ID_W-1:0]           head_id_q;
  logic [DELAY_BITS-1:0]     head_delta_q;

  // Entry memory port signals.
  logic                      ram_we;
  logic [IW-1:0]             ram_waddr;
  logic [ENT_W-1:0]          ram_wdata;
  logic [ENT_W-1:0]          ram_rdata;
  logic [ID_W-1:0]           rd_id;
  logic [DELAY_BITS-1:0]     rd_delta;

  // Shared arithmetic unit signals.
  dltq_pkg::alu_op_e         alu_op;
  logic [DELAY_BITS-1:0]     alu_a, alu_b, alu_res;
  logic                      alu_le;

  logic                      scan_last;
  logic                      id_match;

  assign rd_id    = ram_rdata[DELAY_BITS +: ID_W];
  assign rd_delta = ram_rdata[DELAY_BITS-1:0];

  // The memory read address is the next index, so that in every cycle the
  // registered read data already holds the entry at the current index.
  dltq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (idx_d),
    .rdata_o (ram_rdata)
  );

  dltq_alu #(
    .WIDTH (DELAY_BITS)
  ) u_alu (
    .op_i     (alu_op),
    .a_i      (alu_a),
    .b_i      (alu_b),
    .result_o (alu_res),
    .le_o     (alu_le)
  );

  assign scan_last = (CW'(idx_q) == (count_q - CW'(1)));
  assign id_match  = (rd_id == id_q);

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    count_d   = count_q;
    done_d    = 1'b0;
    status_d  = status_q;
    placed_d  = placed_q;
    dup_d     = dup_q;
    cmd_d     = cmd_q;
    id_d      = id_q;
    rem_d     = rem_q;
    pos_d     = pos_q;

    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = ram_rdata;

    alu_op    = dltq_pkg::ALU_SUB;
    alu_a     = rem_q;
    alu_b     = rd_delta;

    unique case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (start) begin
          cmd_d    = dltq_pkg::cmd_e'(command_i);
          id_d     = timer_id_i;
          rem_d    = DELAY_BITS'(delay_i);
          placed_d = 1'b0;
          dup_d    = 1'b0;
          case (dltq_pkg::cmd_e'(command_i))
            dltq_pkg::CMD_INSERT: begin
              state_d = (count_q == '0) ? ST_DECIDE : ST_SCAN;
            end
            dltq_pkg::CMD_CANCEL: begin
              if (count_q == '0) begin
                done_d   = 1'b1;
                status_d = dltq_pkg::STATUS_NOT_FOUND;
              end else begin
                state_d = ST_SCAN;
              end
            end
            dltq_pkg::CMD_TICK: begin
              state_d = ST_TICK;
            end
            default: begin
              done_d   = 1'b1;
              status_d = dltq_pkg::STATUS_OK;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (cmd_q == dltq_pkg::CMD_INSERT) begin
          // The duplicate check covers every entry, even after placement.
          dup_d = dup_q | id_match;
          if (!placed_q) begin
            if (alu_le) begin
              placed_d = 1'b1;
              pos_d    = idx_q;
            end else begin
              rem_d = alu_res;
            end
          end
          if (scan_last) begin
            state_d = ST_DECIDE;
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end else begin
          // Cancel stops at the first match and keeps the removed delta.
          if (id_match) begin
            pos_d = idx_q;
            rem_d = rd_delta;
            if (scan_last) begin
              state_d  = ST_IDLE;
              done_d   = 1'b1;
              status_d = dltq_pkg::STATUS_OK;
              count_d  = count_q - CW'(1);
            end else begin
              state_d = ST_SHDN;
              idx_d   = idx_q + IW'(1);
            end
          end else if (scan_last) begin
            state_d  = ST_IDLE;
            done_d   = 1'b1;
            status_d = dltq_pkg::STATUS_NOT_FOUND;
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end
      end

      ST_DECIDE: begin
        if (dup_q) begin
          state_d  = ST_IDLE;
          done_d   = 1'b1;
          status_d = dltq_pkg::STATUS_DUP;
        end else if (count_q == CW'(QUEUE_DEPTH)) begin
          state_d  = ST_IDLE;
          done_d   = 1'b1;
          status_d = dltq_pkg::STATUS_FULL;
        end else if (!placed_q) begin
          // The new timer goes after every queued entry.
          pos_d   = IW'(count_q);
          state_d = ST_WRNEW;
        end else begin
          idx_d   = IW'(count_q - CW'(1));
          state_d = ST_SHUP;
        end
      end

      ST_SHUP: begin
        // Move entry idx up by one; the entry at the insert position also
        // gives up the remaining delay of the new timer.
        alu_a     = rd_delta;
        alu_b     = rem_q;
        ram_we    = 1'b1;
        ram_waddr = idx_q + IW'(1);
        ram_wdata = {rd_id, (idx_q == pos_q) ? alu_res : rd_delta};
        if (idx_q == pos_q) begin
          state_d = ST_WRNEW;
        end else begin
          idx_d = idx_q - IW'(1);
        end
      end

      ST_WRNEW: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q;
        ram_wdata = {id_q, rem_q};
        state_d   = ST_IDLE;
        done_d    = 1'b1;
        status_d  = dltq_pkg::STATUS_OK;
        count_d   = count_q + CW'(1);
      end

      ST_SHDN: begin
        // Move entry idx down by one; the successor of the removed entry
        // absorbs its delta, saturating at the largest delay.
        alu_op    = dltq_pkg::ALU_ADD_SAT;
        alu_a     = rd_delta;
        alu_b     = rem_q;
        ram_we    = 1'b1;
        ram_waddr = idx_q - IW'(1);
        ram_wdata = {rd_id, (idx_q == (pos_q + IW'(1))) ? alu_res : rd_delta};
        if (scan_last) begin
          state_d  = ST_IDLE;
          done_d   = 1'b1;
          status_d = dltq_pkg::STATUS_OK;
          count_d  = count_q - CW'(1);
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end

      ST_TICK: begin
        alu_a     = head_delta_q;
        alu_b     = DELAY_BITS'(1);
        ram_waddr = '0;
        ram_wdata = {head_id_q, alu_res};
        ram_we    = (count_q != '0) && (head_delta_q != '0);
        idx_d     = '0;
        state_d   = ST_IDLE;
        done_d    = 1'b1;
        status_d  = dltq_pkg::STATUS_OK;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= dltq_pkg::STATUS_OK;
      placed_q <= 1'b0;
      dup_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      count_q  <= count_d;
      done_q   <= done_d;
      status_q <= status_d;
      placed_q <= placed_d;
      dup_q    <= dup_d;
    end
  end

  // Command payload and the head shadow; every write of entry 0 also
  // refreshes the shadow, so the two never disagree.
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    id_q  <= id_d;
    rem_q <= rem_d;
    pos_q <= pos_d;
    if (ram_we && (ram_waddr == '0)) begin
      head_id_q    <= ram_wdata[DELAY_BITS +: ID_W];
      head_delta_q <= ram_wdata[DELAY_BITS-1:0];
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign head_expired_o = (count_q != '0) && (head_delta_q == '0);
  assign head_id_o      = (count_q != '0) ? head_id_q : '0;
  assign entry_count_o  = dltq_pkg::COUNT_OUT_W'(count_q);

  // The queue never holds more entries than the table has rows.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  // A result is only presented once the sequencer has returned to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ST_IDLE))
    else $error("result strobe while sequencer busy");

  // Every accepted command is either still in work or reporting next cycle.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (done_q || busy))
    else $error("accepted command dropped");

  // A successful insert grows the queue by exactly one entry.
  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (status_q == dltq_pkg::STATUS_OK) && (cmd_q == dltq_pkg::CMD_INSERT))
    |-> (count_q == ($past(count_q) + CW'(1))))
    else $error("insert did not add one entry");

  // Memory writes happen only while a command is being worked on.
  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q != ST_IDLE))
    else $error("entry memory written while idle");

endmodule

// ----- rtl/dltq_ram.sv -----
// ============================================================================
// dltq_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ============================================================================
module dltq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/dltq_alu.sv -----
// ============================================================================
// dltq_alu: shared delay arithmetic unit
// One adder that subtracts with a less-or-equal compare, or adds with
// saturation at the largest delay value.
// ============================================================================
module dltq_alu #(
  parameter int unsigned WIDTH = 32
) (
  input  dltq_pkg::alu_op_e op_i,
  input  logic [WIDTH-1:0]  a_i,
  input  logic [WIDTH-1:0]  b_i,
  output logic [WIDTH-1:0]  result_o,
  output logic              le_o
);

  logic             is_sub;
  logic [WIDTH:0]   sum;
  logic [WIDTH-1:0] b_op;

  // Subtraction is a + ~b + 1; its carry out is set when a >= b.
  always_comb begin
    is_sub   = (op_i == dltq_pkg::ALU_SUB);
    b_op     = is_sub ? ~b_i : b_i;
    sum      = {1'b0, a_i} + {1'b0, b_op} + {{WIDTH{1'b0}}, is_sub};
    le_o     = !sum[WIDTH] || (sum[WIDTH-1:0] == '0);
    result_o = (!is_sub && sum[WIDTH]) ? '1 : sum[WIDTH-1:0];
  end

endmodule

// ----- bench/timer_queue_checker.sv -----
`timescale 1ns / 100ps
// ============================================================================
// timer_queue_checker: result checker for the delta-list timer queue
// Watches the command and result transactions of the queue core, keeps its
// own copy of the sorted delta table, and compares every result against the
// queue state expected after the matching command.
// ============================================================================
module timer_queue_checker #(
  parameter int unsigned DEPTH   = dltq_pkg::QUEUE_DEPTH,
  parameter int unsigned DELAY_W = dltq_pkg::DELAY_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             busy_i,
  input  logic [dltq_pkg::CMD_W-1:0]       command_i,
  input  logic [dltq_pkg::ID_W-1:0]        timer_id_i,
  input  logic [dltq_pkg::IN_DELAY_W-1:0]  delay_i,
  input  logic                             done_i,
  input  logic [dltq_pkg::STATUS_W-1:0]    status_i,
  input  logic                             head_expired_i,
  input  logic [dltq_pkg::ID_W-1:0]        head_id_i,
  input  logic [dltq_pkg::COUNT_OUT_W-1:0] entry_count_i,
  output int                               fail_count_o,
  output int                               pending_o
);

  typedef struct packed {
    dltq_pkg::status_e                status;
    logic                             expired;
    logic [dltq_pkg::ID_W-1:0]        head;
    logic [dltq_pkg::COUNT_OUT_W-1:0] count;
  } queue_report_t;

  logic [dltq_pkg::ID_W-1:0] id_slots[DEPTH];
  logic [DELAY_W-1:0]        delta_slots[DEPTH];
  int                        occupied;
  queue_report_t             queue_reports[$];
  int                        failures;

  function automatic int locate_id(input logic [dltq_pkg::ID_W-1:0] id);
    for (int i = 0; i < occupied; i++) begin
      if (id_slots[i] == id) return i;
    end
    return -1;
  endfunction

  task automatic insert_timer(input logic [dltq_pkg::ID_W-1:0] id,
                              input logic [dltq_pkg::IN_DELAY_W-1:0] dly,
                              output dltq_pkg::status_e st);
    int                 pos;
    int                 k;
    logic [DELAY_W-1:0] remaining;
    remaining = DELAY_W'(dly);
    if (locate_id(id) >= 0) begin
      st = dltq_pkg::STATUS_DUP;
    end else if (occupied >= int'(DEPTH)) begin
      st = dltq_pkg::STATUS_FULL;
    end else begin
      // Walk past every entry that expires strictly earlier.
      pos = 0;
      while (pos < occupied && remaining > delta_slots[pos]) begin
        remaining = remaining - delta_slots[pos];
        pos++;
      end
      if (pos < occupied) delta_slots[pos] = delta_slots[pos] - remaining;
      for (k = occupied; k > pos; k--) begin
        id_slots[k]    = id_slots[k-1];
        delta_slots[k] = delta_slots[k-1];
      end
      id_slots[pos]    = id;
      delta_slots[pos] = remaining;
      occupied++;
      st = dltq_pkg::STATUS_OK;
    end
  endtask

  task automatic cancel_timer(input logic [dltq_pkg::ID_W-1:0] id,
                              output dltq_pkg::status_e st);
    int               pos;
    int               k;
    logic [DELAY_W:0] merged;
    pos = locate_id(id);
    if (pos < 0) begin
      st = dltq_pkg::STATUS_NOT_FOUND;
    end else begin
      // The successor inherits the removed delta, saturating on overflow.
      if (pos + 1 < occupied) begin
        merged = {1'b0, delta_slots[pos+1]} + {1'b0, delta_slots[pos]};
        delta_slots[pos+1] = merged[DELAY_W] ? '1 : merged[DELAY_W-1:0];
      end
      for (k = pos; k + 1 < occupied; k++) begin
        id_slots[k]    = id_slots[k+1];
        delta_slots[k] = delta_slots[k+1];
      end
      occupied--;
      st = dltq_pkg::STATUS_OK;
    end
  endtask

  task automatic run_timer_command(input dltq_pkg::cmd_e op,
                                   input logic [dltq_pkg::ID_W-1:0] id,
                                   input logic [dltq_pkg::IN_DELAY_W-1:0] dly,
                                   output queue_report_t rep);
    dltq_pkg::status_e st;
    st = dltq_pkg::STATUS_OK;
    case (op)
      dltq_pkg::CMD_INSERT: insert_timer(id, dly, st);
      dltq_pkg::CMD_CANCEL: cancel_timer(id, st);
      dltq_pkg::CMD_TICK: begin
        if (occupied > 0 && delta_slots[0] != '0) delta_slots[0] = delta_slots[0] - 1'b1;
      end
      default: ;
    endcase
    rep.status  = st;
    rep.expired = (occupied > 0) && (delta_slots[0] == '0);
    rep.head    = (occupied > 0) ? id_slots[0] : '0;
    rep.count   = dltq_pkg::COUNT_OUT_W'(occupied);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    queue_report_t seen;
    queue_report_t wanted;
    queue_report_t predicted;
    if (!rst_ni) begin
      occupied = 0;
      failures = 0;
      queue_reports.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // Retire the result first: a result never belongs to a command
      // accepted at the same edge.
      if (done_i) begin
        seen.status  = dltq_pkg::status_e'(status_i);
        seen.expired = head_expired_i;
        seen.head    = head_id_i;
        seen.count   = entry_count_i;
        if (queue_reports.size() == 0) begin
          failures++;
          if (failures <= 10) begin
            $display("%0t: result with no command outstanding: status %0d expired %0b",
                     $realtime, status_i, head_expired_i,
                     " head %h count %0d", head_id_i, entry_count_i);
          end
        end else begin
          wanted = queue_reports.pop_front();
          if (seen.status !== wanted.status || seen.expired !== wanted.expired ||
              seen.head !== wanted.head || seen.count !== wanted.count) begin
            failures++;
            if (failures <= 10) begin
              $display("%0t: mismatch: expected status %0d expired %0b head %h count %0d",
                       $realtime, wanted.status, wanted.expired, wanted.head, wanted.count);
              $display("%0t:           actual   status %0d expired %0b head %h count %0d",
                       $realtime, status_i, head_expired_i, head_id_i, entry_count_i);
            end
          end
        end
      end
      if (start_i && !busy_i) begin
        run_timer_command(dltq_pkg::cmd_e'(command_i), timer_id_i, delay_i, predicted);
        queue_reports.push_back(predicted);
      end
      fail_count_o <= failures;
      pending_o    <= queue_reports.size();
    end
  end

endmodule

// ----- bench/tb_delta_list_timer_queue_core.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_delta_list_timer_queue_core: testbench of the delta-list timer queue
// Drives a directed run through the corner cases of insert, cancel, tick and
// query, then a long random run that alternates between filling the queue
// and draining it. A separate checker predicts and compares every result.
// ============================================================================
module tb_delta_list_timer_queue_core;

  localparam int ID_W        = dltq_pkg::ID_W;
  localparam int IN_DELAY_W  = dltq_pkg::IN_DELAY_W;
  localparam int STATUS_W    = dltq_pkg::STATUS_W;
  localparam int COUNT_OUT_W = dltq_pkg::COUNT_OUT_W;
  localparam int QUEUE_DEPTH = dltq_pkg::QUEUE_DEPTH;

  localparam int RANDOM_ITEMS  = 1850;
  // The slowest correct run is about 1900 transactions, each with the longest
  // idle gap and the longest insert; the limit is several times that.
  localparam int CYCLE_LIMIT   = 600000;
  // Longest command is an insert into a nearly full table.
  localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH + 8;
  localparam int ID_POOL_SIZE  = 24;

  logic                   clk_i  = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start  = 1'b0;
  dltq_pkg::cmd_e         command_q  = dltq_pkg::CMD_QUERY;
  logic [ID_W-1:0]        timer_id_q = '0;
  logic [IN_DELAY_W-1:0]  delay_q    = '0;

  logic                   busy;
  logic                   done_o;
  logic [STATUS_W-1:0]    status_o;
  logic                   head_expired_o;
  logic [ID_W-1:0]        head_id_o;
  logic [COUNT_OUT_W-1:0] entry_count_o;

  int                     fail_count;
  int                     pending;
  int                     cycle_count = 0;
  int                     burst_left;
  logic [ID_W-1:0]        id_pool[ID_POOL_SIZE];

  always #6 clk_i = ~clk_i;

  delta_list_timer_queue_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_q),
    .timer_id_i     (timer_id_q),
    .delay_i        (delay_q),
    .done_o         (done_o),
    .status_o       (status_o),
    .head_expired_o (head_expired_o),
    .head_id_o      (head_id_o),
    .entry_count_o  (entry_count_o)
  );

  timer_queue_checker report_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .command_i      (command_q),
    .timer_id_i     (timer_id_q),
    .delay_i        (delay_q),
    .done_i         (done_o),
    .status_i       (status_o),
    .head_expired_i (head_expired_o),
    .head_id_i      (head_id_o),
    .entry_count_i  (entry_count_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAIL delta_list_timer_queue_core");
    $finish;
  end

  // Presents one command transaction and holds it until the core takes it.
  // The caller is always sitting on a rising edge. Start is left high when
  // the burst continues, so that the next command follows back to back;
  // otherwise it drops for a random gap. Most bursts are short, but some
  // run long so that there are stretches with no idling at all.
  task automatic send_command(input dltq_pkg::cmd_e op, input logic [ID_W-1:0] id,
                              input logic [IN_DELAY_W-1:0] dly);
    int gap;
    start      <= 1'b1;
    command_q  <= op;
    timer_id_q <= id;
    delay_q    <= dly;
    do @(posedge clk_i); while (busy);
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      // Short gaps land inside the core's walk; long ones outlast it.
      gap = ($urandom_range(99) < 70) ? $urandom_range(1, 4) : $urandom_range(5, 40);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(99) < 75) ? $urandom_range(1, 8) : $urandom_range(20, 80);
    end
  endtask

  // Delays favor small values, so that ticks actually expire heads, but
  // full-range and near-maximum values are common enough to toggle every
  // bit and to stress the subtraction along the walk.
  function automatic logic [IN_DELAY_W-1:0] pick_delay();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return IN_DELAY_W'($urandom_range(12));
    if (r < 55) return IN_DELAY_W'($urandom_range(2000));
    if (r < 80) return IN_DELAY_W'($urandom);
    if (r < 92) return {IN_DELAY_W{1'b1}} - IN_DELAY_W'($urandom_range(3));
    return '0;
  endfunction

  // Ids mostly come from a small pool so that duplicates and cancels of
  // queued timers are frequent; the rest are arbitrary and almost always
  // unknown to the queue.
  function automatic logic [ID_W-1:0] pick_id();
    if ($urandom_range(99) < 85) return id_pool[$urandom_range(ID_POOL_SIZE - 1)];
    return ID_W'($urandom_range(16'hFFFF));
  endfunction

  // A fill phase leans on inserts and drives the table to full; a drain
  // phase leans on cancels and empties it. Ticks and queries carry random
  // id and delay bits, which the core must ignore.
  task automatic random_timer_command(input bit filling);
    int unsigned    r;
    dltq_pkg::cmd_e op;
    r = $urandom_range(99);
    if (filling) begin
      op = (r < 60) ? dltq_pkg::CMD_INSERT : (r < 75) ? dltq_pkg::CMD_CANCEL :
           (r < 95) ? dltq_pkg::CMD_TICK : dltq_pkg::CMD_QUERY;
    end else begin
      op = (r < 20) ? dltq_pkg::CMD_INSERT : (r < 70) ? dltq_pkg::CMD_CANCEL :
           (r < 92) ? dltq_pkg::CMD_TICK : dltq_pkg::CMD_QUERY;
    end
    case (op)
      dltq_pkg::CMD_INSERT: send_command(op, pick_id(), pick_delay());
      dltq_pkg::CMD_CANCEL: send_command(op, pick_id(), IN_DELAY_W'($urandom));
      default:              send_command(op, ID_W'($urandom), IN_DELAY_W'($urandom));
    endcase
  endtask

  initial begin
    bit filling;
    int phase_left;
    id_pool[0] = '0;
    id_pool[1] = '1;
    id_pool[2] = 16'h8000;
    id_pool[3] = 16'h0001;
    for (int i = 4; i < ID_POOL_SIZE; i++) id_pool[i] = ID_W'($urandom_range(16'hFFFF));
    burst_left = $urandom_range(1, 8);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. An empty queue first: query, tick and a cancel that
    // cannot find anything.
    send_command(dltq_pkg::CMD_QUERY,  16'h0000, 32'h0000_0000);
    send_command(dltq_pkg::CMD_TICK,   16'h0000, 32'h0000_0000);
    send_command(dltq_pkg::CMD_CANCEL, 16'h1234, 32'h0000_0000);
    // A zero delay expires immediately; then the largest id and delay.
    send_command(dltq_pkg::CMD_INSERT, 16'h0000, 32'h0000_0000);
    send_command(dltq_pkg::CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    // Equal delays: the new timer goes first and its successor's delta
    // drops to zero.
    send_command(dltq_pkg::CMD_INSERT, 16'h0005, 32'hFFFF_FFFF);
    // Duplicate id leaves the queue untouched.
    send_command(dltq_pkg::CMD_INSERT, 16'h0000, 32'h0000_0009);
    // Tick with an expired head changes nothing; the head stays queued.
    send_command(dltq_pkg::CMD_TICK,   16'h0000, 32'h0000_0000);
    // Cancel from the middle, then the head, then a real tick.
    send_command(dltq_pkg::CMD_CANCEL, 16'h0005, 32'h0000_0000);
    send_command(dltq_pkg::CMD_CANCEL, 16'h0000, 32'h0000_0000);
    send_command(dltq_pkg::CMD_TICK,   16'hABCD, 32'hFFFF_FFFF);
    // Unknown id on a nonempty queue.
    send_command(dltq_pkg::CMD_CANCEL, 16'h4321, 32'h0000_0000);
    // Fill the table, then hit it with a new id (full) and with a queued
    // id (duplicate wins over full).
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      send_command(dltq_pkg::CMD_INSERT, ID_W'(16'h0100 + i), pick_delay());
    end
    send_command(dltq_pkg::CMD_INSERT, 16'h7777, 32'h0000_0001);
    send_command(dltq_pkg::CMD_INSERT, 16'hFFFF, 32'h0000_0001);

    // Random part, starting with a drain since the table is full.
    filling    = 1'b0;
    phase_left = $urandom_range(80, 160);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      random_timer_command(filling);
      phase_left--;
      if (phase_left <= 0) begin
        filling    = !filling;
        phase_left = $urandom_range(80, 160);
      end
    end
    start <= 1'b0;

    // Let the last acceptance reach the checker, wait for every result,
    // then give the core time to show any stray result.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("PASS delta_list_timer_queue_core");
    end else begin
      $display("FAIL delta_list_timer_queue_core");
    end
    $finish;
  end

endmodule
